>>> rtl/lmfx_pkg.sv
// Shared types, codes, limits and pixel helpers for the LED matrix effect engine.
package lmfx_pkg;

    // Field widths
    localparam int CMD_W       = 2;
    localparam int ROW_NUM_W   = 3;
    localparam int BYTE_W      = 8;
    localparam int INTENS_W    = 4;
    localparam int ORIENT_W    = 2;
    localparam int BRIGHT_W    = 5;
    localparam int INTERVAL_W  = 16;
    localparam int EFFECT_W    = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int TICK_W      = 7;
    localparam int SCRATCH_W   = 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_ROW = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET_ATTR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_RENDER_INTERVAL = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EFFECT_SELECT   = 1'd1;

    // Effect codes
    localparam logic [EFFECT_W-1:0] FX_SLIDE_DOWN  = 4'd1;
    localparam logic [EFFECT_W-1:0] FX_SLIDE_UP    = 4'd2;
    localparam logic [EFFECT_W-1:0] FX_SLIDE_RIGHT = 4'd3;
    localparam logic [EFFECT_W-1:0] FX_SLIDE_LEFT  = 4'd4;
    localparam logic [EFFECT_W-1:0] FX_INTERLACE   = 4'd5;
    localparam logic [EFFECT_W-1:0] FX_ROTATE      = 4'd6;
    localparam logic [EFFECT_W-1:0] FX_BLINK       = 4'd7;
    localparam logic [EFFECT_W-1:0] FX_FLASH       = 4'd8;
    localparam logic [EFFECT_W-1:0] FX_FLICKER     = 4'd9;
    localparam logic [EFFECT_W-1:0] FX_COLLAPSE    = 4'd10;
    localparam logic [EFFECT_W-1:0] FX_GLITCH      = 4'd11;
    localparam logic [EFFECT_W-1:0] FX_THROB       = 4'd12;

    // Orientation codes
    localparam logic [ORIENT_W-1:0] FACE_NORTH = 2'd0;
    localparam logic [ORIENT_W-1:0] FACE_EAST  = 2'd1;
    localparam logic [ORIENT_W-1:0] FACE_WEST  = 2'd3;

    // Reset values
    localparam logic [INTERVAL_W-1:0] RENDER_INTERVAL_RESET = 16'd300;
    localparam logic [BRIGHT_W-1:0]   INTENSITY_RESET       = 5'd15;

    // Effect limits and periods
    localparam logic [TICK_W-1:0]    TICK_LAST          = 7'd99;
    localparam logic [3:0]           FLASH_LAST         = 4'd9;
    localparam logic [3:0]           FLASH_SHOW_PHASE   = 4'd5;
    localparam logic [4:0]           COLLAPSE_LAST      = 5'd19;
    localparam logic [SCRATCH_W-1:0] INTERLACE_LIMIT    = 8'd16;
    localparam logic [SCRATCH_W-1:0] FLICKER_LIMIT      = 8'd36;
    localparam logic [SCRATCH_W-1:0] GLITCH_FAST_LIMIT  = 8'd74;
    localparam logic [SCRATCH_W-1:0] GLITCH_FLICK_LIMIT = 8'd100;
    localparam logic [SCRATCH_W-1:0] GLITCH_ILACE_LIMIT = 8'd64;
    localparam logic [BRIGHT_W-1:0]  THROB_TOP          = 5'd16;
    localparam logic [15:0]          ELAPSED_MAX        = 16'hFFFF;

    // Eight row bytes of the bitmap
    typedef logic [7:0][BYTE_W-1:0] rows_t;

    // One finished frame handed to the line serializer
    typedef struct packed {
        rows_t               lines;
        logic                drive_column;
        logic                straight;
        logic [BRIGHT_W-1:0] brightness;
    } frame_t;

    function automatic logic [BYTE_W-1:0] rot_r(input logic [BYTE_W-1:0] b);
        return {b[0], b[BYTE_W-1:1]};
    endfunction

    function automatic logic [BYTE_W-1:0] rot_l(input logic [BYTE_W-1:0] b);
        return {b[BYTE_W-2:0], b[BYTE_W-1]};
    endfunction

    // Even rows rotate left, odd rows rotate right.
    function automatic rows_t interlace(input rows_t r);
        rows_t o;
        for (int x = 0; x < 8; x++)
        begin
            o[x] = x[0] ? rot_r(r[x]) : rot_l(r[x]);
        end
        return o;
    endfunction

endpackage

>>> rtl/lmfx_in_if.sv
// Input channel carrying one command beat.
interface lmfx_in_if;
    import lmfx_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [ROW_NUM_W-1:0] row_number;
    logic [BYTE_W-1:0]    row_bits;
    logic [INTENS_W-1:0]  new_intensity;
    logic [ORIENT_W-1:0]  new_orientation;
    logic                 new_inverted;

    modport source (
        output valid, command, row_number, row_bits, new_intensity,
               new_orientation, new_inverted,
        input  ready
    );

    modport sink (
        input  valid, command, row_number, row_bits, new_intensity,
               new_orientation, new_inverted,
        output ready
    );
endinterface

>>> rtl/lmfx_out_if.sv
// Output channel carrying one line write beat.
interface lmfx_out_if;
    import lmfx_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 drive_column;
    logic [ROW_NUM_W-1:0] line_index;
    logic [BYTE_W-1:0]    line_bits;
    logic [BRIGHT_W-1:0]  brightness;
    logic                 last_line;

    modport source (
        output valid, drive_column, line_index, line_bits, brightness, last_line,
        input  ready
    );

    modport sink (
        input  valid, drive_column, line_index, line_bits, brightness, last_line,
        output ready
    );
endinterface

>>> rtl/lmfx_core.sv
// Command register, bitmap state, render timer and effect logic.
module lmfx_core (
    input  logic                               clk,
    input  logic                               rst_n,
    lmfx_in_if.sink                            in_ch,
    input  logic                               cfg_we,
    input  logic [lmfx_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lmfx_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               emit_free,
    output logic                               frame_load,
    output lmfx_pkg::frame_t                   frame
);
    import lmfx_pkg::*;

    // Command register
    logic                 item_valid_reg;
    logic [CMD_W-1:0]     cmd_reg;
    logic [ROW_NUM_W-1:0] row_number_reg;
    logic [BYTE_W-1:0]    row_bits_reg;
    logic [INTENS_W-1:0]  new_intensity_reg;
    logic [ORIENT_W-1:0]  new_orientation_reg;
    logic                 new_inverted_reg;

    // Configuration
    logic [INTERVAL_W-1:0] render_interval_reg;
    logic [EFFECT_W-1:0]   effect_reg;

    // Display state. The first byte of the hidden copy also serves as the
    // interlace and throb counter, since both share that scratch byte.
    rows_t                 rows_reg, rows_next;
    rows_t                 hidden_reg, hidden_next;
    logic [BRIGHT_W-1:0]   intensity_reg, intensity_next;
    logic                  invert_reg, invert_next;
    logic [ORIENT_W-1:0]   facing_reg, facing_next;
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic [3:0]            phase10_reg, phase10_next;
    logic [4:0]            phase20_reg, phase20_next;
    logic [15:0]           elapsed_reg, elapsed_next;
    logic [SCRATCH_W-1:0]  scr9_reg, scr9_next;
    logic [SCRATCH_W-1:0]  scr10_reg, scr10_next;

    logic [15:0] elapsed_inc;
    logic        render_due;
    logic        advance;

    // Render decision and hold-off while the serializer is still full
    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 16'd1;
    assign render_due  = item_valid_reg && (cmd_reg == CMD_TICK)
                         && (elapsed_inc >= render_interval_reg);
    assign advance     = item_valid_reg && !(render_due && !emit_free);
    assign in_ch.ready = !item_valid_reg || advance;
    assign frame_load  = advance && render_due;

    // Command register load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            item_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            cmd_reg             <= in_ch.command;
            row_number_reg      <= in_ch.row_number;
            row_bits_reg        <= in_ch.row_bits;
            new_intensity_reg   <= in_ch.new_intensity;
            new_orientation_reg <= in_ch.new_orientation;
            new_inverted_reg    <= in_ch.new_inverted;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            render_interval_reg <= RENDER_INTERVAL_RESET;
            effect_reg          <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RENDER_INTERVAL: render_interval_reg <= cfg_data[INTERVAL_W-1:0];
                REG_EFFECT_SELECT:   effect_reg <= cfg_data[EFFECT_W-1:0];
                default:             ;
            endcase
        end
    end

    // Next state for one command, with the effect applied on a render
    always_comb
    begin
        logic [SCRATCH_W-1:0] s0;
        logic [SCRATCH_W-1:0] s9;
        logic [SCRATCH_W-1:0] s10;
        logic                 hide;

        rows_next      = rows_reg;
        hidden_next    = hidden_reg;
        intensity_next = intensity_reg;
        invert_next    = invert_reg;
        facing_next    = facing_reg;
        tick_next      = tick_reg;
        phase10_next   = phase10_reg;
        phase20_next   = phase20_reg;
        elapsed_next   = elapsed_reg;
        scr9_next      = scr9_reg;
        scr10_next     = scr10_reg;
        s0             = (hidden_reg[0] == '0) ? 8'd1 : hidden_reg[0];
        s9             = (scr9_reg == '0) ? 8'd1 : scr9_reg;
        s10            = (scr10_reg == '0) ? 8'd1 : scr10_reg;
        hide           = 1'b0;

        if (advance)
        begin
            case (cmd_reg)
                CMD_LOAD_ROW:
                begin
                    rows_next[row_number_reg] = row_bits_reg;
                end
                CMD_SET_ATTR:
                begin
                    intensity_next = {1'b0, new_intensity_reg};
                    facing_next    = new_orientation_reg;
                    invert_next    = new_inverted_reg;
                end
                CMD_TICK:
                begin
                    elapsed_next = elapsed_inc;
                    if (render_due)
                    begin
                        elapsed_next = '0;
                        case (effect_reg)
                            FX_SLIDE_DOWN:
                            begin
                                rows_next = {rows_reg[6:0], rows_reg[7]};
                            end
                            FX_SLIDE_UP:
                            begin
                                rows_next = {rows_reg[0], rows_reg[7:1]};
                            end
                            FX_SLIDE_RIGHT:
                            begin
                                for (int x = 0; x < 8; x++)
                                begin
                                    rows_next[x] = rot_r(rows_reg[x]);
                                end
                            end
                            FX_SLIDE_LEFT:
                            begin
                                for (int x = 0; x < 8; x++)
                                begin
                                    rows_next[x] = rot_l(rows_reg[x]);
                                end
                            end
                            FX_INTERLACE:
                            begin
                                hidden_next[0] = s0;
                                if (s0 <= INTERLACE_LIMIT)
                                begin
                                    rows_next      = interlace(rows_reg);
                                    hidden_next[0] = s0 + 8'd1;
                                end
                            end
                            FX_ROTATE:
                            begin
                                facing_next = facing_reg + 2'd1;
                            end
                            FX_BLINK:
                            begin
                                invert_next = !invert_reg;
                            end
                            FX_FLASH:
                            begin
                                if (phase10_reg == '0)
                                begin
                                    hidden_next = rows_reg;
                                    rows_next   = '0;
                                end
                                else if (phase10_reg == FLASH_SHOW_PHASE)
                                begin
                                    rows_next = hidden_reg;
                                end
                            end
                            FX_FLICKER:
                            begin
                                scr9_next = s9;
                                if (s9 <= FLICKER_LIMIT)
                                begin
                                    if (!tick_reg[0])
                                    begin
                                        hidden_next = rows_reg;
                                        rows_next   = '0;
                                    end
                                    else
                                    begin
                                        rows_next = hidden_reg;
                                    end
                                    scr9_next = s9 + 8'd1;
                                end
                            end
                            FX_COLLAPSE:
                            begin
                                if (phase20_reg == '0)
                                begin
                                    rows_next[6:1] = rows_reg[5:0];
                                    rows_next[7]   = rows_reg[7] | rows_reg[5];
                                end
                            end
                            FX_GLITCH:
                            begin
                                scr9_next  = s9;
                                scr10_next = s10;
                                if (s9 <= GLITCH_FLICK_LIMIT)
                                begin
                                    hide = (s9 <= GLITCH_FAST_LIMIT) ? !tick_reg[0]
                                                                     : (tick_reg[1:0] == 2'd0);
                                    if (hide)
                                    begin
                                        hidden_next = rows_reg;
                                        rows_next   = '0;
                                    end
                                    else
                                    begin
                                        rows_next = hidden_reg;
                                    end
                                    scr9_next = s9 + 8'd1;
                                end
                                if (s10 <= GLITCH_ILACE_LIMIT)
                                begin
                                    rows_next  = interlace(rows_next);
                                    scr10_next = s10 + 8'd1;
                                end
                            end
                            FX_THROB:
                            begin
                                if (hidden_reg[0] == '0)
                                begin
                                    if (intensity_reg != '0)
                                    begin
                                        intensity_next = intensity_reg - 5'd1;
                                    end
                                    else
                                    begin
                                        hidden_next[0] = 8'd1;
                                    end
                                end
                                else if (intensity_reg < THROB_TOP)
                                begin
                                    intensity_next = intensity_reg + 5'd1;
                                end
                                else
                                begin
                                    intensity_next = THROB_TOP;
                                    hidden_next[0] = '0;
                                end
                            end
                            default:
                            begin
                            end
                        endcase

                        // Frame tick and its phases wrap together every hundred renders.
                        if (tick_reg == TICK_LAST)
                        begin
                            tick_next    = '0;
                            phase10_next = '0;
                            phase20_next = '0;
                        end
                        else
                        begin
                            tick_next    = tick_reg + 7'd1;
                            phase10_next = (phase10_reg == FLASH_LAST) ? 4'd0
                                                                       : phase10_reg + 4'd1;
                            phase20_next = (phase20_reg == COLLAPSE_LAST) ? 5'd0
                                                                          : phase20_reg + 5'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= '0;
            hidden_reg    <= '0;
            intensity_reg <= INTENSITY_RESET;
            invert_reg    <= 1'b0;
            facing_reg    <= FACE_EAST;
            tick_reg      <= '0;
            phase10_reg   <= '0;
            phase20_reg   <= '0;
            elapsed_reg   <= '0;
            scr9_reg      <= '0;
            scr10_reg     <= '0;
        end
        else
        begin
            rows_reg      <= rows_next;
            hidden_reg    <= hidden_next;
            intensity_reg <= intensity_next;
            invert_reg    <= invert_next;
            facing_reg    <= facing_next;
            tick_reg      <= tick_next;
            phase10_reg   <= phase10_next;
            phase20_reg   <= phase20_next;
            elapsed_reg   <= elapsed_next;
            scr9_reg      <= scr9_next;
            scr10_reg     <= scr10_next;
        end
    end

    // Frame as it will be shown: inverted lines and orientation flags
    always_comb
    begin
        for (int x = 0; x < 8; x++)
        begin
            frame.lines[x] = rows_next[x] ^ {BYTE_W{invert_next}};
        end
        frame.drive_column = (facing_next == FACE_EAST) || (facing_next == FACE_WEST);
        frame.straight     = (facing_next == FACE_NORTH) || (facing_next == FACE_WEST);
        frame.brightness   = intensity_next;
    end

endmodule

>>> rtl/lmfx_emit.sv
// Frame buffer that sends a rendered frame as eight line write beats.
module lmfx_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             frame_load,
    input  lmfx_pkg::frame_t frame,
    output logic             emit_free,
    lmfx_out_if.source       out_ch
);
    import lmfx_pkg::*;

    logic                 busy_reg;
    logic [ROW_NUM_W-1:0] line_reg;
    frame_t               frame_reg;
    logic                 fire;
    logic                 at_last;

    assign fire      = busy_reg && out_ch.ready;
    assign at_last   = (line_reg == {ROW_NUM_W{1'b1}});
    assign emit_free = !busy_reg || (fire && at_last);

    // Line counter and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            line_reg <= '0;
        end
        else if (frame_load)
        begin
            busy_reg <= 1'b1;
            line_reg <= '0;
        end
        else if (fire)
        begin
            busy_reg <= !at_last;
            line_reg <= line_reg + 3'd1;
        end
    end

    // Frame capture
    always_ff @(posedge clk)
    begin
        if (frame_load)
        begin
            frame_reg <= frame;
        end
    end

    // Beat fields
    assign out_ch.valid        = busy_reg;
    assign out_ch.drive_column = frame_reg.drive_column;
    assign out_ch.line_index   = frame_reg.straight ? line_reg : ~line_reg;
    assign out_ch.line_bits    = frame_reg.lines[line_reg];
    assign out_ch.brightness   = frame_reg.brightness;
    assign out_ch.last_line    = at_last;

endmodule

>>> rtl/led_matrix_effect_engine_top.sv
// Order: a command beat is registered on acceptance and applied from the command register; a
// render's frame is captured as applied, then its line write beats go one per cycle while ready.
// Throughput: one command beat per cycle but for render stalls; a render occupies the serializer
// for eight beats; a later rendering tick waits in the command register until the last is taken.
// Reset (rst_n, asynchronous, active low): blank bitmap, intensity 15, facing east, not
// inverted, counters and effect scratch cleared, render interval 300, effect none.
module led_matrix_effect_engine_top (
    input  logic                             clk,
    input  logic                             rst_n,
    lmfx_in_if.sink                          in_ch,
    lmfx_out_if.source                       out_ch,
    input  logic                             cfg_we,
    input  logic [lmfx_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lmfx_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lmfx_pkg::*;

    logic   frame_load;
    logic   emit_free;
    frame_t frame;

    // Command handling and effects
    lmfx_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .emit_free  (emit_free),
        .frame_load (frame_load),
        .frame      (frame)
    );

    // Line write serializer
    lmfx_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_load (frame_load),
        .frame      (frame),
        .emit_free  (emit_free),
        .out_ch     (out_ch)
    );

endmodule
